### rtl/cgla_pkg.sv
package cgla_pkg;

    // default sizes
    localparam int DEF_MAX_SLOTS   = 256;
    localparam int DEF_MAX_CLASSES = 16;
    localparam int DEF_MAX_MEMBERS = 32;

    // fixed field widths
    localparam int KEY_W      = 32;
    localparam int TICK_W     = 32;
    localparam int SLOT_NUM_W = 9;
    localparam int S_TDATA_W  = 72;
    localparam int M_TDATA_W  = 16;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_ALLOC = 1'b1
    } t_opcode;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_EMPTY    = 2'd1,
        ST_NO_CLASS = 2'd2,
        ST_FULL     = 2'd3
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_KEY,
        S_EXEC,
        S_SCAN,
        S_WB,
        S_DONE
    } t_state;

    typedef struct packed {
        t_opcode            op;
        logic [KEY_W-1:0]   key;
        logic               enroll;
        logic [TICK_W-1:0]  tick;
    } t_req;

    typedef struct packed {
        logic [SLOT_NUM_W-1:0] slot_number;
        t_status               status;
    } t_res;

endpackage

### rtl/cgla_core.sv
module cgla_core
    import cgla_pkg::*;
#(
    parameter int MAX_SLOTS             = DEF_MAX_SLOTS,
    parameter int MAX_CLASSES           = DEF_MAX_CLASSES,
    parameter int MAX_MEMBERS_PER_CLASS = DEF_MAX_MEMBERS
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_req_valid,
    output logic o_req_ready,
    input  t_req i_req,
    output logic o_res_valid,
    input  logic i_res_ready,
    output t_res o_res
);

    localparam int CW     = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
    localparam int TW     = $clog2(MAX_CLASSES + 1);
    localparam int MW     = (MAX_MEMBERS_PER_CLASS > 1) ? $clog2(MAX_MEMBERS_PER_CLASS) : 1;
    localparam int NW     = $clog2(MAX_MEMBERS_PER_CLASS + 1);
    localparam int XW     = $clog2(MAX_SLOTS);
    localparam int SW     = $clog2(MAX_SLOTS + 1);
    localparam int MA     = CW + MW;
    localparam int MDEPTH = MAX_CLASSES * (1 << MW);
    localparam int CE_W   = KEY_W + NW;
    localparam int ME_W   = XW + TICK_W;

    t_state r_state, n_state;
    t_req   r_req;
    t_res   r_res;

    logic [TW-1:0]     r_class_total;
    logic [SW-1:0]     r_slot_total;

    // class search
    logic [TW-1:0]     r_ci;
    logic              r_kv;
    logic [CW-1:0]     r_kidx;
    logic              r_found;
    logic [CW-1:0]     r_cls;
    logic [NW-1:0]     r_cnt;

    // member scan
    logic [NW-1:0]     r_mj;
    logic              r_mv;
    logic [MW-1:0]     r_midx;
    logic              r_bv;
    logic [MW-1:0]     r_best_j;
    logic [TICK_W-1:0] r_best_stamp;
    logic [XW-1:0]     r_best_slot;

    // class table: key and member count per class
    logic [CE_W-1:0]   r_class_mem [MAX_CLASSES];
    logic [CE_W-1:0]   r_cm_q;
    // member table: slot index and last-use stamp per enrolled slot
    logic [ME_W-1:0]   r_member_mem [MDEPTH];
    logic [ME_W-1:0]   r_mm_q;

    logic              key_rd, key_hit, key_miss;
    logic [KEY_W-1:0]  cm_q_key;
    logic [NW-1:0]     cm_q_cnt;
    logic              mm_rd, take, scan_end;
    logic [XW-1:0]     mm_q_slot;
    logic [TICK_W-1:0] mm_q_stamp;
    logic              add_full, add_ok, alloc_go;
    logic [CW-1:0]     add_cls;
    logic [NW-1:0]     add_cnt;
    logic [XW:0]       add_num, wb_num;
    logic              cm_we, mm_we;
    logic [CE_W-1:0]   cm_wdata;
    logic [MA-1:0]     mm_waddr;
    logic [ME_W-1:0]   mm_wdata;

    assign cm_q_key   = r_cm_q[NW +: KEY_W];
    assign cm_q_cnt   = r_cm_q[NW-1:0];
    assign mm_q_slot  = r_mm_q[TICK_W +: XW];
    assign mm_q_stamp = r_mm_q[TICK_W-1:0];

    assign key_rd   = (r_state == S_KEY) && (r_ci < r_class_total);
    assign key_hit  = (r_state == S_KEY) && r_kv && (cm_q_key == r_req.key);
    assign key_miss = (r_state == S_KEY) && !r_kv && !key_rd;

    // stop early once a zero stamp is held, nothing can beat it
    assign mm_rd    = (r_state == S_SCAN) && (r_mj < r_cnt)
                      && !(r_bv && (r_best_stamp == '0));
    assign take     = r_mv && (!r_bv || (mm_q_stamp < r_best_stamp));
    assign scan_end = (r_state == S_SCAN) && !mm_rd && !r_mv;

    assign add_full = (r_slot_total >= SW'(MAX_SLOTS))
                      || (!r_found && (r_class_total >= TW'(MAX_CLASSES)))
                      || (r_req.enroll && r_found
                          && (r_cnt >= NW'(MAX_MEMBERS_PER_CLASS)));
    assign add_ok   = (r_state == S_EXEC) && (r_req.op == OP_ADD) && !add_full;
    assign alloc_go = (r_req.op == OP_ALLOC) && r_found && (r_cnt != '0);
    assign add_cls  = r_found ? r_cls : r_class_total[CW-1:0];
    assign add_cnt  = r_found ? r_cnt : '0;
    assign add_num  = {1'b0, r_slot_total[XW-1:0]} + (XW+1)'(1);
    assign wb_num   = {1'b0, r_best_slot} + (XW+1)'(1);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (i_req_valid) n_state = S_KEY;
            S_KEY:  if (key_hit || key_miss) n_state = S_EXEC;
            S_EXEC: n_state = (alloc_go) ? S_SCAN : S_DONE;
            S_SCAN: if (scan_end) n_state = S_WB;
            S_WB:   n_state = S_DONE;
            S_DONE: if (i_res_ready) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // outputs and memory write ports
    always_comb begin
        o_req_ready = (r_state == S_IDLE);
        o_res_valid = (r_state == S_DONE);
        o_res       = r_res;
        cm_we       = add_ok && (!r_found || r_req.enroll);
        cm_wdata    = {r_req.key, add_cnt + NW'(r_req.enroll)};
        mm_we       = 1'b0;
        mm_waddr    = {add_cls, add_cnt[MW-1:0]};
        mm_wdata    = {r_slot_total[XW-1:0], {TICK_W{1'b0}}};
        case (r_state)
            S_EXEC: mm_we = add_ok && r_req.enroll;
            S_WB: begin
                mm_we    = 1'b1;
                mm_waddr = {r_cls, r_best_j};
                mm_wdata = {r_best_slot, r_req.tick};
            end
            default: mm_we = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (key_rd) r_cm_q <= r_class_mem[r_ci[CW-1:0]];
        if (cm_we) r_class_mem[add_cls] <= cm_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (mm_rd) r_mm_q <= r_member_mem[{r_cls, r_mj[MW-1:0]}];
        if (mm_we) r_member_mem[mm_waddr] <= mm_wdata;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= S_IDLE;
            r_class_total <= '0;
            r_slot_total  <= '0;
            r_kv          <= 1'b0;
            r_mv          <= 1'b0;
            r_bv          <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                S_IDLE: begin
                    if (i_req_valid) begin
                        r_req <= i_req;
                        r_ci  <= '0;
                        r_kv  <= 1'b0;
                    end
                end
                S_KEY: begin
                    r_ci   <= r_ci + TW'(key_rd);
                    r_kv   <= key_rd;
                    r_kidx <= r_ci[CW-1:0];
                    if (key_hit) begin
                        r_found <= 1'b1;
                        r_cls   <= r_kidx;
                        r_cnt   <= cm_q_cnt;
                    end else if (key_miss) begin
                        r_found <= 1'b0;
                        r_cnt   <= '0;
                    end
                end
                S_EXEC: begin
                    r_mj <= '0;
                    r_mv <= 1'b0;
                    r_bv <= 1'b0;
                    r_res.slot_number <= '0;
                    if (r_req.op == OP_ADD) begin
                        if (add_full) begin
                            r_res.status <= ST_FULL;
                        end else begin
                            r_res.status      <= ST_OK;
                            r_res.slot_number <= SLOT_NUM_W'(add_num);
                            r_slot_total      <= r_slot_total + SW'(1);
                            if (!r_found) r_class_total <= r_class_total + TW'(1);
                        end
                    end else if (!r_found) begin
                        r_res.status <= ST_NO_CLASS;
                    end else if (r_cnt == '0) begin
                        r_res.status <= ST_EMPTY;
                    end else begin
                        r_res.status <= ST_OK;
                    end
                end
                S_SCAN: begin
                    r_mj   <= r_mj + NW'(mm_rd);
                    r_mv   <= mm_rd;
                    r_midx <= r_mj[MW-1:0];
                    if (take) begin
                        r_bv         <= 1'b1;
                        r_best_stamp <= mm_q_stamp;
                        r_best_j     <= r_midx;
                        r_best_slot  <= mm_q_slot;
                    end
                end
                S_WB: begin
                    r_res.status      <= ST_OK;
                    r_res.slot_number <= SLOT_NUM_W'(wb_num);
                end
                default: r_kv <= 1'b0;
            endcase
        end
    end

    a_totals_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_class_total <= TW'(MAX_CLASSES)) && (r_slot_total <= SW'(MAX_SLOTS)))
        else $error("class or slot total beyond capacity");

    a_class_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_class_total != $past(r_class_total))
        |-> (r_class_total == $past(r_class_total) + TW'(1)))
        else $error("class total moved by more than one");

    a_hit_in_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        key_hit |-> (TW'(r_kidx) < r_class_total))
        else $error("key hit on an unused class entry");

    a_wb_has_best: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WB) |-> r_bv)
        else $error("stamp write-back without a chosen member");

    a_cnt_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |-> (r_cnt <= NW'(MAX_MEMBERS_PER_CLASS)))
        else $error("member count beyond class capacity");

endmodule

### rtl/class_grouped_lru_slot_allocator.sv
// channel   | dir | tdata (lsb up)                                   | tuser         | tlast
// s_axis    | in  | descriptor_key[31:0] enroll[32] tick[64:33] pad  | opcode[0]     | -
// m_axis    | out | slot_number[8:0] pad                             | status[1:0]   | -
//
// one request at a time: an add or a failed lookup searches the class table for the key,
// an allocate on a found class with members also scans them for the oldest stamp
// the class search and the member stamp scan each read one memory entry a cycle
// synchronous active-low reset clears the class and slot totals; no clearing pass,
// stamps are written to zero as slots are enrolled
// the result sits in an output register so the next request is taken while it waits
module class_grouped_lru_slot_allocator
    import cgla_pkg::*;
#(
    parameter int MAX_SLOTS             = DEF_MAX_SLOTS,
    parameter int MAX_CLASSES           = DEF_MAX_CLASSES,
    parameter int MAX_MEMBERS_PER_CLASS = DEF_MAX_MEMBERS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,   // descriptor_key, enroll, tick, zero pad
    input  logic                 s_axis_tuser,   // opcode
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,   // slot_number, zero pad
    output logic [1:0]           m_axis_tuser    // status
);

    t_req req;
    t_res core_res;
    t_res r_m_res;
    logic r_m_valid;
    logic core_res_valid;
    logic core_res_ready;
    logic load;

    // unpack the request
    assign req.op     = t_opcode'(s_axis_tuser);
    assign req.key    = s_axis_tdata[KEY_W-1:0];
    assign req.enroll = s_axis_tdata[KEY_W];
    assign req.tick   = s_axis_tdata[KEY_W+1 +: TICK_W];

    cgla_core #(
        .MAX_SLOTS             (MAX_SLOTS),
        .MAX_CLASSES           (MAX_CLASSES),
        .MAX_MEMBERS_PER_CLASS (MAX_MEMBERS_PER_CLASS)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (s_axis_tvalid),
        .o_req_ready (s_axis_tready),
        .i_req       (req),
        .o_res_valid (core_res_valid),
        .i_res_ready (core_res_ready),
        .o_res       (core_res)
    );

    // output register, refilled in the cycle the old result leaves
    assign core_res_ready = !r_m_valid || m_axis_tready;
    assign load           = core_res_valid && core_res_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (load) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) r_m_res <= core_res;
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = {{(M_TDATA_W-SLOT_NUM_W){1'b0}}, r_m_res.slot_number};
    assign m_axis_tuser  = r_m_res.status;

endmodule
